### hdl/bsdl_pkg.sv
// ----------------------------------------------------------------------------
// bsdl_pkg
// Shared types, constants and helpers for the bounded sorted deque list.
// ----------------------------------------------------------------------------
package bsdl_pkg;

   localparam int DEPTH     = 64;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_REG_W = 7;
   localparam int CAP_W     = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;
   localparam int WORD_W    = 32;
   localparam int CNT_OUT_W = 7;
   localparam int ADDR_W    = 3;

   // Register addresses
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_SORT_DESC = 1'b1;

   // Commands
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;
   localparam cmd_type CMD_PEEK   = 2'd3;

   // Status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

   // Per-cell compare selection
   typedef logic [2:0] match_kind_type;
   localparam match_kind_type KIND_LT   = 3'd0;
   localparam match_kind_type KIND_GT   = 3'd1;
   localparam match_kind_type KIND_EQ   = 3'd2;
   localparam match_kind_type KIND_ONE  = 3'd3;
   localparam match_kind_type KIND_ZERO = 3'd4;

   typedef struct packed {
      logic           load;    // capture match bit this cycle
      match_kind_type kind;    // compare for occupied cells
      logic           beyond;  // match bit for cells at or past the count
   } match_ctl_type;

   // Cell update
   typedef logic [1:0] cell_op_type;
   localparam cell_op_type OP_HOLD  = 2'd0;
   localparam cell_op_type OP_LOAD  = 2'd1;
   localparam cell_op_type OP_LEFT  = 2'd2;
   localparam cell_op_type OP_RIGHT = 2'd3;

   // Inclusive prefix OR, lowest index first; log-depth doubling
   function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
      logic [DEPTH-1:0] r;
      r = v;
      for (int s = 1; s < DEPTH; s = s * 2) begin
         r = r | (r << s);
      end
      return r;
   endfunction

endpackage

### hdl/bsdl_cell.sv
// ----------------------------------------------------------------------------
// bsdl_cell
// One list slot: holds a word, compares it against the broadcast value and
// takes its next word from itself, the value, or either neighbor.
// ----------------------------------------------------------------------------
module bsdl_cell
   import bsdl_pkg::*;
(
   input  logic                clock,
   input  match_ctl_type       match_ctl,
   input  logic                below_count,
   input  logic [WORD_W-1:0]   value,
   input  cell_op_type         op,
   input  logic [WORD_W-1:0]   left_word,
   input  logic [WORD_W-1:0]   right_word,
   output logic [WORD_W-1:0]   word,
   output logic                match
);

   logic [WORD_W-1:0] word_ff, word_in;
   logic              match_ff, match_in;
   logic              cmp;

   always_comb begin
      case (match_ctl.kind)
         KIND_LT:   cmp = $signed(word_ff) < $signed(value);
         KIND_GT:   cmp = $signed(word_ff) > $signed(value);
         KIND_EQ:   cmp = (word_ff == value);
         KIND_ONE:  cmp = 1'b1;
         KIND_ZERO: cmp = 1'b0;
         default:   cmp = 1'b0;
      endcase
      match_in = match_ctl.load ? (below_count ? cmp : match_ctl.beyond) : match_ff;
   end

   always_comb begin
      case (op)
         OP_HOLD:  word_in = word_ff;
         OP_LOAD:  word_in = value;
         OP_LEFT:  word_in = left_word;
         OP_RIGHT: word_in = right_word;
         default:  word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

### hdl/bounded_sorted_deque_list_top.sv
// ----------------------------------------------------------------------------
// bounded_sorted_deque_list_top
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The accepting edge loads every cell's compare bit and moves to the execute
// state; the execute step then resolves the first-match position, shifts the row
// in one step and writes the result word into the output register. A new
// request is taken only after the execute step of the last one is done.
// A result waiting in the output register stalls only the execute cycle.
// Reset clears the count, the control state and the registers (capacity 64,
// descending); the cell words are not cleared.
module bounded_sorted_deque_list_top
   import bsdl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [31:0] value
   input  logic [3:0]           req_tuser,   // [1:0] command, [2] at_tail, [3] sorted_insert
   // response
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // [31:0] data_out, [38:32] entry_count,
                                             // [39] is_full, [40] is_empty, [47:41] zero
   output logic [1:0]           rsp_tuser,   // [1:0] status
   // configuration
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CAP_REG_W-1:0]  cap_ff;
   logic                  desc_ff;
   cmd_type               cmd_ff;
   logic [WORD_W-1:0]     val_ff;
   logic                  tail_ff;

   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     rsp_data_ff;
   logic [CNT_OUT_W-1:0]  rsp_cnt_ff;
   logic                  rsp_full_ff, rsp_empty_ff;
   status_type            rsp_status_ff;

   logic                  accept, exec_go, csr_wr;
   logic [CAP_W-1:0]      cap_ext, eff_cap;
   logic                  full_now, empty_now, found;
   logic                  do_insert, do_shift_left;
   status_type            status;
   logic [WORD_W-1:0]     data_sel;
   logic [IDX_W-1:0]      tail_idx;
   match_ctl_type         match_ctl;
   cmd_type               req_cmd;
   logic                  req_tail, req_sorted;

   logic [WORD_W-1:0]     words [DEPTH];
   logic [DEPTH-1:0]      match_vec, mask, below;
   cell_op_type           ops [DEPTH];

   assign req_cmd    = req_tuser[1:0];
   assign req_tail   = req_tuser[2];
   assign req_sorted = req_tuser[3];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Effective capacity clamped to 1..DEPTH
   always_comb begin
      cap_ext = CAP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ext > CAP_W'(DEPTH)) begin
         eff_cap = CAP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full_now  = CAP_W'(cnt_ff) >= eff_cap;
   assign empty_now = (cnt_ff == '0);

   // Compare setup, applied by every cell at accept
   always_comb begin
      match_ctl.load   = accept;
      match_ctl.kind   = KIND_ZERO;
      match_ctl.beyond = 1'b0;
      case (req_cmd)
         CMD_INSERT: begin
            match_ctl.beyond = 1'b1;
            if (req_sorted) begin
               match_ctl.kind = desc_ff ? KIND_LT : KIND_GT;
            end else begin
               match_ctl.kind = req_tail ? KIND_ZERO : KIND_ONE;
            end
         end
         CMD_DELETE: begin
            match_ctl.kind = KIND_EQ;
         end
         CMD_REMOVE: begin
            match_ctl.kind   = req_tail ? KIND_ZERO : KIND_ONE;
            match_ctl.beyond = !req_tail;
         end
         CMD_PEEK: begin
            match_ctl.kind = KIND_ZERO;
         end
         default: begin
            match_ctl.kind = KIND_ZERO;
         end
      endcase
   end

   // Mask is set from the first matching cell onward
   assign mask  = prefix_or(match_vec);
   assign found = mask[DEPTH-1];

   assign do_insert     = exec_go && (cmd_ff == CMD_INSERT) && !full_now;
   assign do_shift_left = exec_go && !empty_now &&
                          (((cmd_ff == CMD_DELETE) && found) ||
                           ((cmd_ff == CMD_REMOVE) && !tail_ff));

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_cell
         logic [WORD_W-1:0] left_w, right_w;
         logic              mask_prev;

         assign below[k] = CNT_W'(k) < cnt_ff;

         if (k == 0) begin : g_first
            assign left_w    = val_ff;
            assign mask_prev = 1'b0;
         end else begin : g_mid
            assign left_w    = words[k-1];
            assign mask_prev = mask[k-1];
         end

         if (k == DEPTH - 1) begin : g_last
            assign right_w = words[k];
         end else begin : g_inner
            assign right_w = words[k+1];
         end

         always_comb begin
            if (do_insert && mask[k]) begin
               ops[k] = mask_prev ? OP_LEFT : OP_LOAD;
            end else if (do_shift_left && mask[k]) begin
               ops[k] = OP_RIGHT;
            end else begin
               ops[k] = OP_HOLD;
            end
         end

         bsdl_cell u_cell (
            .clock       (clock),
            .match_ctl   (match_ctl),
            .below_count (below[k]),
            .value       (accept ? req_tdata : val_ff),
            .op          (ops[k]),
            .left_word   (left_w),
            .right_word  (right_w),
            .word        (words[k]),
            .match       (match_vec[k])
         );
      end
   endgenerate

   assign tail_idx = IDX_W'(cnt_ff - CNT_W'(1));

   always_comb begin
      status   = ST_OK;
      data_sel = '0;
      cnt_in   = cnt_ff;
      if (cmd_ff == CMD_INSERT) begin
         if (full_now) begin
            status = ST_FULL;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else if (empty_now) begin
         status = ST_EMPTY;
      end else if (cmd_ff == CMD_DELETE) begin
         if (!found) begin
            status = ST_NOT_FOUND;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end else begin
         data_sel = tail_ff ? words[tail_idx] : words[0];
         if (cmd_ff == CMD_REMOVE) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept)  state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CAP_REG_W'(64);
         desc_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            cnt_ff <= cnt_in;
         end
         if (csr_wr) begin
            if (csr_paddr[2] == REG_CAPACITY) begin
               cap_ff <= csr_pwdata[CAP_REG_W-1:0];
            end else begin
               desc_ff <= csr_pwdata[0];
            end
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         val_ff  <= req_tdata;
         tail_ff <= req_tail;
      end
      if (exec_go) begin
         rsp_status_ff <= status;
         rsp_data_ff   <= data_sel;
         rsp_cnt_ff    <= CNT_OUT_W'(cnt_in);
         rsp_full_ff   <= CAP_W'(cnt_in) >= eff_cap;
         rsp_empty_ff  <= (cnt_in == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_empty_ff, rsp_full_ff, rsp_cnt_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? 32'(cap_ff) : 32'(desc_ff);

endmodule

### dv/tb_bounded_sorted_deque_list_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_sorted_deque_list_top
// Self-checking bench for the bounded sorted deque list. A queue-based model
// tracks the list and predicts every response word. Directed commands cover
// empty, full, not-found and capacity corner cases. Random phases then run
// under changing capacity and sort order, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_deque_list_top
   import bsdl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 1000000;
   localparam logic [ADDR_W-1:0] CAP_ADDR  = ADDR_W'(4 * REG_CAPACITY);
   localparam logic [ADDR_W-1:0] SORT_ADDR = ADDR_W'(4 * REG_SORT_DESC);

   typedef struct {
      cmd_type     cmd;
      logic [31:0] value;
      logic        at_tail;
      logic        sorted;
   } list_cmd_type;

   typedef struct {
      status_type  status;
      logic [31:0] data;
      logic [6:0]  count;
      logic        full;
      logic        empty;
   } list_rsp_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [31:0] value
   logic [3:0]  req_tuser   = '0;   // [1:0] command, [2] at_tail, [3] sorted_insert
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;          // [31:0] data_out, [38:32] entry_count,
                                    // [39] is_full, [40] is_empty, [47:41] zero
   logic [1:0]  rsp_tuser;          // [1:0] status
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // model state
   logic [31:0] list_q[$];
   logic [6:0]  cap_setting = 7'd64;
   logic        sort_desc   = 1'b1;

   list_cmd_type cmd_q[$];
   list_rsp_type predicted_rsp_q[$];
   list_cmd_type cur_cmd = list_cmd_type'{CMD_INSERT, 32'd0, 1'b0, 1'b0};
   bit          offered  = 1'b0;
   bit          draining = 1'b0;
   bit          steady   = 1'b0;
   int          send_gap = 0;
   int          stall    = 0;
   int          errors   = 0;
   int          cycles   = 0;
   logic [31:0] pool[8];

   bounded_sorted_deque_list_top i_dut (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // mostly short gaps, a few long; none in steady stretches
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic list_rsp_type apply_command(list_cmd_type c);
      list_rsp_type r;
      int        lim;
      int        n;
      int        pos;
      r.status = ST_OK;
      r.data   = '0;
      lim = cap_setting;
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      n = list_q.size();
      if (c.cmd == CMD_INSERT) begin
         if (n >= lim) begin
            r.status = ST_FULL;
         end else if (c.sorted) begin
            // equal entries stay ahead of the new word
            pos = n;
            for (int i = 0; i < n; i++) begin
               if (sort_desc ? ($signed(list_q[i]) < $signed(c.value))
                             : ($signed(list_q[i]) > $signed(c.value))) begin
                  pos = i;
                  break;
               end
            end
            list_q.insert(pos, c.value);
         end else if (c.at_tail) begin
            list_q.push_back(c.value);
         end else begin
            list_q.push_front(c.value);
         end
      end else if (n == 0) begin
         r.status = ST_EMPTY;
      end else if (c.cmd == CMD_DELETE) begin
         pos = -1;
         for (int i = 0; i < n; i++) begin
            if (list_q[i] == c.value) begin
               pos = i;
               break;
            end
         end
         if (pos < 0) r.status = ST_NOT_FOUND;
         else list_q.delete(pos);
      end else begin
         r.data = c.at_tail ? list_q[n-1] : list_q[0];
         if (c.cmd == CMD_REMOVE) begin
            if (c.at_tail) void'(list_q.pop_back());
            else void'(list_q.pop_front());
         end
      end
      n = list_q.size();
      r.count = 7'(n);
      r.full  = (n >= lim);
      r.empty = (n == 0);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsp_q.push_back(apply_command(cur_cmd));
            offered = 1'b0;
         end
         if (!offered) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (draining) begin
               if (predicted_rsp_q.size() == 0) draining = 1'b0;
            end else if (cmd_q.size() > 0) begin
               cur_cmd  = cmd_q.pop_front();
               offered  = 1'b1;
               send_gap = gap_len();
               if ($urandom_range(0, 149) == 0) draining = 1'b1;
            end
         end
         req_tvalid <= offered;
         req_tdata  <= cur_cmd.value;
         req_tuser  <= {cur_cmd.sorted, cur_cmd.at_tail, cur_cmd.cmd};
      end
   end

   // response monitor
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("response word with nothing expected: tdata=%h tuser=%h",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[31:0] !== want.data) begin
                  $error("data_out: expected %0d, got %0d",
                         $signed(want.data), $signed(rsp_tdata[31:0]));
                  errors++;
               end
               if (rsp_tdata[38:32] !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_tdata[38:32]);
                  errors++;
               end
               if (rsp_tdata[39] !== want.full) begin
                  $error("is_full: expected %0d, got %0d", want.full, rsp_tdata[39]);
                  errors++;
               end
               if (rsp_tdata[40] !== want.empty) begin
                  $error("is_empty: expected %0d, got %0d", want.empty, rsp_tdata[40]);
                  errors++;
               end
               if (rsp_tdata[47:41] !== 7'd0) begin
                  $error("pad: expected 0, got %0d", rsp_tdata[47:41]);
                  errors++;
               end
            end
            stall = gap_len();
         end else if (!rsp_tvalid && stall == 0 && $urandom_range(0, 9) == 0) begin
            stall = gap_len();
         end
         rsp_tready <= (stall == 0);
         if (stall > 0) stall--;
      end
   end

   task automatic add_cmd(cmd_type cmd, logic [31:0] value, logic tail, logic srt);
      cmd_q.push_back(list_cmd_type'{cmd, value, tail, srt});
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return pool[$urandom_range(0, 7)];
      if (r < 70) return $urandom();
      if (r < 85) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd1;
            default: return 32'd0;
         endcase
      end
      return 32'($urandom_range(0, 8) - 4);
   endfunction

   task automatic add_random(int count, int ins_pct);
      cmd_type cmd;
      int      r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) cmd = CMD_INSERT;
         else case ($urandom_range(0, 2))
            0: cmd = CMD_DELETE;
            1: cmd = CMD_REMOVE;
            default: cmd = CMD_PEEK;
         endcase
         add_cmd(cmd, pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (cmd_q.size() != 0 || req_tvalid || predicted_rsp_q.size() != 0);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] wdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CAP_ADDR) cap_setting = wdata[6:0];
      else sort_desc = wdata[0];
   endtask

   // upper bits are don't-care and get random fill
   task automatic set_config(logic [6:0] cap, logic desc);
      csr_write(CAP_ADDR, ($urandom() & ~32'h7F) | 32'(cap));
      csr_write(SORT_ADDR, ($urandom() & ~32'h1) | 32'(desc));
   endtask

   initial begin
      int caps[14]    = '{127, 64, 3, 1, 64, 0, 2, 100, 17, 64, 5, 64, 1, 40};
      int ins_pct[14] = '{85, 90, 50, 60, 80, 40, 55, 60, 70, 20, 60, 85, 50, 35};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset config: capacity 64, descending
      add_cmd(CMD_PEEK,   32'd0, 1'b0, 1'b0);
      add_cmd(CMD_PEEK,   32'd0, 1'b1, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b0, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b1, 1'b0);
      add_cmd(CMD_DELETE, 32'd0, 1'b0, 1'b0);
      add_cmd(CMD_INSERT, 32'd5, 1'b0, 1'b0);
      add_cmd(CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0);
      add_cmd(CMD_INSERT, 32'h8000_0000, 1'b0, 1'b1);
      add_cmd(CMD_INSERT, 32'd3, 1'b0, 1'b1);
      add_cmd(CMD_INSERT, 32'd3, 1'b1, 1'b1);   // equal value lands behind
      add_cmd(CMD_DELETE, 32'd1234, 1'b0, 1'b0);
      add_cmd(CMD_DELETE, 32'd3, 1'b1, 1'b1);
      add_cmd(CMD_PEEK,   32'hFFFF_FFFF, 1'b0, 1'b1);
      add_cmd(CMD_PEEK,   32'd0, 1'b1, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b1, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b0, 1'b1);
      add_cmd(CMD_REMOVE, 32'd0, 1'b0, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b1, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b1, 1'b1);
      wait_idle();

      // ascending, capacity 2: fill and hit full
      set_config(7'd2, 1'b0);
      add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1);
      add_cmd(CMD_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b1);
      add_cmd(CMD_INSERT, 32'd0, 1'b0, 1'b0);
      add_cmd(CMD_INSERT, 32'h8000_0000, 1'b0, 1'b1);
      wait_idle();

      // zero capacity acts as one; count now above it
      set_config(7'd0, 1'b1);
      add_cmd(CMD_PEEK,   32'd0, 1'b0, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b0, 1'b0);
      add_cmd(CMD_REMOVE, 32'd0, 1'b0, 1'b0);
      wait_idle();

      for (int p = 0; p < 14; p++) begin
         for (int k = 0; k < 8; k++) pool[k] = (k < 2) ? 32'h8000_0000 + k : $urandom();
         steady = ($urandom_range(0, 3) == 0);
         set_config(7'(caps[p]), 1'(p % 3 == 0));
         add_random(100, ins_pct[p]);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (errors == 0 && predicted_rsp_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
